### src/cee_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cee_pkg;

  // Field widths
  localparam int unsigned CodeW  = 21;
  localparam int unsigned CtxW   = 3;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned DataW  = 24;
  localparam int unsigned StrW   = 88;

  // Escape contexts
  localparam logic [CtxW-1:0] CTX_NET     = 3'd0;
  localparam logic [CtxW-1:0] CTX_LIB     = 3'd1;
  localparam logic [CtxW-1:0] CTX_QUOTED  = 3'd2;
  localparam logic [CtxW-1:0] CTX_EOL     = 3'd3;
  localparam logic [CtxW-1:0] CTX_FILE    = 3'd4;
  localparam logic [CtxW-1:0] CTX_NONE    = 3'd5;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_DROP,
    KIND_TOKEN
  } kind_e;

  typedef enum logic [3:0] {
    TOK_SLASH,
    TOK_BRACE,
    TOK_COLON,
    TOK_DBLQUOTE,
    TOK_RETURN,
    TOK_BACKSLASH,
    TOK_LT,
    TOK_GT,
    TOK_BAR,
    TOK_TAB
  } tok_e;

  // Classified word handed from the input stage to the emitter
  typedef struct packed {
    logic             valid;
    kind_e            kind;
    tok_e             tok;
    logic [CodeW-1:0] code;
  } cls_t;

  // Token strings, right-aligned: first character in the highest used byte
  localparam logic [StrW-1:0] STR_SLASH     = StrW'("{slash}");
  localparam logic [StrW-1:0] STR_BRACE     = StrW'("{brace}");
  localparam logic [StrW-1:0] STR_COLON     = StrW'("{colon}");
  localparam logic [StrW-1:0] STR_DBLQUOTE  = StrW'("{dblquote}");
  localparam logic [StrW-1:0] STR_RETURN    = StrW'("{return}");
  localparam logic [StrW-1:0] STR_BACKSLASH = StrW'("{backslash}");
  localparam logic [StrW-1:0] STR_LT        = StrW'("{lt}");
  localparam logic [StrW-1:0] STR_GT        = StrW'("{gt}");
  localparam logic [StrW-1:0] STR_BAR       = StrW'("{bar}");
  localparam logic [StrW-1:0] STR_TAB       = StrW'("{tab}");

  function automatic logic [IdxW-1:0] tok_len(tok_e tok);
    logic [IdxW-1:0] len;
    unique case (tok)
      TOK_SLASH:     len = 4'd7;
      TOK_BRACE:     len = 4'd7;
      TOK_COLON:     len = 4'd7;
      TOK_DBLQUOTE:  len = 4'd10;
      TOK_RETURN:    len = 4'd8;
      TOK_BACKSLASH: len = 4'd11;
      TOK_LT:        len = 4'd4;
      TOK_GT:        len = 4'd4;
      TOK_BAR:       len = 4'd5;
      TOK_TAB:       len = 4'd5;
      default:       len = 4'd1;
    endcase
    return len;
  endfunction

  // Character at position idx of the token
  function automatic logic [7:0] tok_char(tok_e tok, logic [IdxW-1:0] idx);
    logic [StrW-1:0] str;
    logic [IdxW-1:0] len;
    logic [IdxW-1:0] rev;
    logic [7:0]      ch;
    unique case (tok)
      TOK_SLASH:     str = STR_SLASH;
      TOK_BRACE:     str = STR_BRACE;
      TOK_COLON:     str = STR_COLON;
      TOK_DBLQUOTE:  str = STR_DBLQUOTE;
      TOK_RETURN:    str = STR_RETURN;
      TOK_BACKSLASH: str = STR_BACKSLASH;
      TOK_LT:        str = STR_LT;
      TOK_GT:        str = STR_GT;
      TOK_BAR:       str = STR_BAR;
      TOK_TAB:       str = STR_TAB;
      default:       str = '0;
    endcase
    len = tok_len(tok);
    rev = len - 4'd1 - idx;
    if (idx < len) begin
      ch = str[{rev, 3'b000} +: 8];
    end else begin
      ch = 8'h00;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

### src/cee_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module cee_in_stage (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [cee_pkg::CtxW-1:0]   ctx_i,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [cee_pkg::DataW-1:0]  s_axis_tdata,   // [20:0] char_code
  input  wire logic                       consume_i,
  output cee_pkg::cls_t                   cls_o
);
  import cee_pkg::*;

  localparam logic [CodeW-1:0] ChTab    = 21'h09;
  localparam logic [CodeW-1:0] ChLf     = 21'h0A;
  localparam logic [CodeW-1:0] ChCr     = 21'h0D;
  localparam logic [CodeW-1:0] ChDquote = 21'h22;
  localparam logic [CodeW-1:0] ChSlash  = 21'h2F;
  localparam logic [CodeW-1:0] ChColon  = 21'h3A;
  localparam logic [CodeW-1:0] ChLt     = 21'h3C;
  localparam logic [CodeW-1:0] ChGt     = 21'h3E;
  localparam logic [CodeW-1:0] ChBslash = 21'h5C;
  localparam logic [CodeW-1:0] ChLbrace = 21'h7B;
  localparam logic [CodeW-1:0] ChBar    = 21'h7C;

  logic             valid_q;
  logic [CodeW-1:0] code_q;
  logic             eol;
  kind_e            kind;
  tok_e             tok;

  // Take a new word when the register is empty or drains this cycle
  assign s_axis_tready = !valid_q || consume_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      valid_q <= 1'b1;
    end else if (consume_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      code_q <= s_axis_tdata[CodeW-1:0];
    end
  end

  // Classify the held character under the current context
  always_comb begin
    eol  = (code_q == ChLf) || (code_q == ChCr);
    kind = KIND_PASS;
    tok  = TOK_SLASH;
    unique case (ctx_i)
      CTX_NET: begin
        if (code_q == ChSlash) begin
          kind = KIND_TOKEN; tok = TOK_SLASH;
        end else if (eol) begin
          kind = KIND_DROP;
        end
      end
      CTX_LIB: begin
        if (code_q == ChLbrace) begin
          kind = KIND_TOKEN; tok = TOK_BRACE;
        end else if (code_q == ChColon) begin
          kind = KIND_TOKEN; tok = TOK_COLON;
        end else if (eol) begin
          kind = KIND_DROP;
        end
      end
      CTX_QUOTED: begin
        if (code_q == ChDquote) begin
          kind = KIND_TOKEN; tok = TOK_DBLQUOTE;
        end
      end
      CTX_EOL: begin
        if (eol) begin
          kind = KIND_TOKEN; tok = TOK_RETURN;
        end
      end
      CTX_FILE: begin
        kind = KIND_TOKEN;
        priority if (code_q == ChLbrace) tok = TOK_BRACE;
        else if (code_q == ChSlash)      tok = TOK_SLASH;
        else if (code_q == ChBslash)     tok = TOK_BACKSLASH;
        else if (code_q == ChDquote)     tok = TOK_DBLQUOTE;
        else if (code_q == ChLt)         tok = TOK_LT;
        else if (code_q == ChGt)         tok = TOK_GT;
        else if (code_q == ChBar)        tok = TOK_BAR;
        else if (code_q == ChColon)      tok = TOK_COLON;
        else if (code_q == ChTab)        tok = TOK_TAB;
        else if (eol)                    tok = TOK_RETURN;
        else                             kind = KIND_PASS;
      end
      default: begin
        kind = KIND_PASS;
      end
    endcase
  end

  assign cls_o = '{valid: valid_q, kind: kind, tok: tok, code: code_q};

endmodule

`default_nettype wire

### src/cee_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module cee_emit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cee_pkg::cls_t              cls_i,
  output logic                            consume_o,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [cee_pkg::DataW-1:0]       m_axis_tdata,   // [20:0] out_code
  output logic                            m_axis_tlast    // last_of_run
);
  import cee_pkg::*;

  logic             out_valid_q, out_valid_d;
  logic [CodeW-1:0] out_code_q, out_code_d;
  logic             out_last_q, out_last_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             load;
  logic             tok_end;

  // Output register is free when empty or taken this cycle
  assign load    = !out_valid_q || m_axis_tready;
  assign tok_end = (idx_q == tok_len(cls_i.tok) - 4'd1);

  always_comb begin
    out_valid_d = out_valid_q;
    out_code_d  = out_code_q;
    out_last_d  = out_last_q;
    idx_d       = idx_q;
    consume_o   = 1'b0;
    if (load) begin
      out_valid_d = 1'b0;
    end
    if (cls_i.valid) begin
      unique case (cls_i.kind)
        KIND_DROP: begin
          consume_o = 1'b1;
        end
        KIND_PASS: begin
          if (load) begin
            out_valid_d = 1'b1;
            out_code_d  = cls_i.code;
            out_last_d  = 1'b1;
            consume_o   = 1'b1;
          end
        end
        KIND_TOKEN: begin
          // Advance one token character per free output slot
          if (load) begin
            out_valid_d = 1'b1;
            out_code_d  = CodeW'(tok_char(cls_i.tok, idx_q));
            out_last_d  = tok_end;
            if (tok_end) begin
              idx_d     = '0;
              consume_o = 1'b1;
            end else begin
              idx_d = idx_q + 4'd1;
            end
          end
        end
        default: begin
          consume_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_code_q <= out_code_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DataW'(out_code_q);
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

### src/context_escape_encoder_unit.sv
// An accepted input word passes the input register and then the output register.
// Throughput: one word per cycle for pass-through characters while the output is
// not held back; an escaped character holds the input until all characters of its
// token (4 to 11) are sent, counted by the single token character counter.
// Dropped characters are consumed without waiting on the output and give no output.
// Reset (rst_ni, async low) empties both registers and sets the context to none.
`timescale 1ns / 1ps
`default_nettype none

module context_escape_encoder_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [cee_pkg::CtxW-1:0]   cfg_data_i,     // context select
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [cee_pkg::DataW-1:0]  s_axis_tdata,   // [20:0] char_code
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [cee_pkg::DataW-1:0]       m_axis_tdata,   // [20:0] out_code
  output logic                            m_axis_tlast    // last_of_run
);
  import cee_pkg::*;

  logic [CtxW-1:0] ctx_q;
  cls_t            cls;
  logic            consume;

  // Context register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= CTX_NONE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ctx_q <= cfg_data_i;
    end
  end

  cee_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctx_i         (ctx_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .consume_i     (consume),
    .cls_o         (cls)
  );

  cee_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cls_i         (cls),
    .consume_o     (consume),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
